@@ hw/rtl/glvg_pkg.sv @@
package glvg_pkg;

   localparam int MAX_SEGMENTS = 32;

   localparam int DIV_NW = 34;
   localparam int DIV_DW = 17;
   localparam int SQ_W   = 54;
   localparam int RT_W   = 27;

   typedef enum logic [2:0] {
      REG_CELL_SPACING,
      REG_HALF_EXTENT,
      REG_SEGMENT_COUNT,
      REG_MAJOR_INTERVAL,
      REG_MINOR_MAJOR_FADES,
      REG_AXIS_FADE_AND_BG,
      REG_AXIS_COLORS,
      REG_TIER_COLORS
   } reg_index_type;

   typedef struct packed {
      logic [15:0] cell_spacing;
      logic [9:0]  half_extent;
      logic [5:0]  segment_count;
      logic [9:0]  major_interval;
      logic [63:0] minor_major_fades;
      logic [55:0] axis_fade_and_bg;
      logic [47:0] axis_colors;
      logic [47:0] tier_colors;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_MAJOR,
      OP_CLASSIFY,
      OP_DIV_SNAP_X,
      OP_MUL_SNAP_X,
      OP_DIV_SNAP_Z,
      OP_MUL_SNAP_Z,
      OP_DIV_ALONG,
      OP_INIT_ALONG,
      OP_SQUARE_X,
      OP_SQUARE_SUM,
      OP_SQRT,
      OP_SMOOTH,
      OP_T_LOAD,
      OP_F_SQUARE,
      OP_F_CUBIC,
      OP_BLEND,
      OP_NEXT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic out_of_range;
      logic reject;
      logic need_div;
      logic last;
   } status_type;

endpackage

@@ hw/rtl/glvg_div.sv @@
module glvg_div import glvg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] num,
   input  logic [DIV_DW-1:0] den,
   output logic              done,
   output logic [DIV_NW-1:0] quot,
   output logic [DIV_DW-1:0] rem
);

   logic [DIV_NW-1:0] qn_ff, qn_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIV_DW:0]   trial;
   logic              qbit;

   always_comb begin
      trial   = {rem_ff, qn_ff[DIV_NW-1]};
      qbit    = (trial >= {1'b0, den_ff});
      qn_in   = qn_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         qn_in  = num;
         rem_in = '0;
         den_in = den;
         cnt_in = 6'(DIV_NW);
      end else if (cnt_ff != 6'd0) begin
         if (qbit) begin
            rem_in = DIV_DW'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[DIV_DW-1:0];
         end
         qn_in   = {qn_ff[DIV_NW-2:0], qbit};
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      qn_ff  <= qn_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = qn_ff;
   assign rem  = rem_ff;

endmodule

@@ hw/rtl/glvg_isqrt.sv @@
module glvg_isqrt import glvg_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SQ_W-1:0] radicand,
   output logic            done,
   output logic [RT_W-1:0] root
);

   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [RT_W+3:0]   rem_ff, rem_in;
   logic [RT_W-1:0]   root_ff, root_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [RT_W+3:0]   cur;
   logic [RT_W+3:0]   trial;

   always_comb begin
      cur     = {rem_ff[RT_W+1:0], rad_ff[SQ_W-1:SQ_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'(RT_W);
      end else if (cnt_ff != 5'd0) begin
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 5'd1;
         done_in = (cnt_ff == 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hw/rtl/glvg_dpath.sv @@
module glvg_dpath import glvg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [31:0] req_focus_x,
   input  logic signed [31:0] req_focus_z,
   input  logic signed [10:0] req_line_offset,
   input  logic               req_orientation,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_z,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_last_vertex
);

   logic [15:0] s_eff;
   logic [5:0]  segs_eff;

   logic signed [31:0] fx_ff, fz_ff;
   logic [10:0]        aoff_ff;
   logic               neg_ff, orient_ff;
   logic [26:0]        cmag_ff;
   logic [25:0]        ext_ff;
   logic [23:0]        color_ff;
   logic [15:0]        e0_ff, e1_ff;
   logic               reject_ff;
   logic signed [34:0] cx_ff, cz_ff;
   logic [26:0]        aq_ff;
   logic [6:0]         ar_ff;
   logic [26:0]        accq_ff;
   logic [6:0]         accr_ff;
   logic [5:0]         k_ff;
   logic [53:0]        sqx_ff;
   logic [26:0]        adz_ff;
   logic [SQ_W-1:0]    sum_ff;
   logic signed [31:0] posx_ff, posz_ff;
   logic [16:0]        t_ff;
   logic [32:0]        tt_ff;
   logic [17:0]        w_ff;
   logic [16:0]        f_ff;
   logic [7:0]         red_ff, green_ff, blue_ff;

   logic              div_start;
   logic [DIV_NW-1:0] div_num;
   logic [DIV_DW-1:0] div_den;
   logic              div_done;
   logic [DIV_NW-1:0] div_quot;
   logic [DIV_DW-1:0] div_rem;
   logic              sq_start;
   logic              sq_done;
   logic [RT_W-1:0]   sq_root;

   logic [10:0]        in_aoff;
   logic [31:0]        afx, afz;
   logic signed [27:0] along, cpos, dx, dz;
   logic [26:0]        adx, adz;
   logic signed [35:0] px, pz;
   logic [49:0]        snap_mag;
   logic [50:0]        fprod;
   logic [51:0]        fround;
   logic [7:0]         chan [3];
   logic [7:0]         ca, cb;
   logic signed [8:0]  cdiff;
   logic signed [26:0] cprod;
   logic signed [27:0] ctot;
   logic [7:0]         acc_r_sum;
   logic [15:0]        d_lo;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   assign s_eff = (cfg.cell_spacing == 16'd0) ? 16'd1 : cfg.cell_spacing;

   always_comb begin
      if (cfg.segment_count == 6'd0) begin
         segs_eff = 6'd1;
      end else if (cfg.segment_count > 6'(MAX_SEGMENTS)) begin
         segs_eff = 6'(MAX_SEGMENTS);
      end else begin
         segs_eff = cfg.segment_count;
      end
   end

   assign in_aoff = req_line_offset[10] ? 11'(-req_line_offset) : req_line_offset;
   assign afx     = fx_ff[31] ? 32'(-fx_ff) : fx_ff;
   assign afz     = fz_ff[31] ? 32'(-fz_ff) : fz_ff;

   assign along = $signed({1'b0, accq_ff}) - $signed({2'b00, ext_ff});
   assign cpos  = neg_ff ? -$signed({1'b0, cmag_ff}) : $signed({1'b0, cmag_ff});
   assign dx    = orient_ff ? along : cpos;
   assign dz    = orient_ff ? cpos : along;
   assign adx   = dx[27] ? 27'(-dx) : dx[26:0];
   assign adz   = dz[27] ? 27'(-dz) : dz[26:0];
   assign px    = 36'(cx_ff) + 36'(dx);
   assign pz    = 36'(cz_ff) + 36'(dz);

   assign snap_mag  = div_quot * s_eff;
   assign fprod     = tt_ff * w_ff;
   assign fround    = 52'(fprod) + 52'h0_0000_8000_0000;
   assign acc_r_sum = {1'b0, accr_ff} + {1'b0, ar_ff};
   assign d_lo      = sq_root[15:0] - e0_ff;

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      sq_start  = 1'b0;
      case (cmd.op)
         OP_DIV_MAJOR: begin
            div_start = 1'b1;
            div_num   = DIV_NW'(aoff_ff);
            div_den   = DIV_DW'(cfg.major_interval);
         end
         OP_DIV_SNAP_X: begin
            div_start = 1'b1;
            div_num   = DIV_NW'({afx, 1'b0}) + DIV_NW'(s_eff);
            div_den   = {s_eff, 1'b0};
         end
         OP_DIV_SNAP_Z: begin
            div_start = 1'b1;
            div_num   = DIV_NW'({afz, 1'b0}) + DIV_NW'(s_eff);
            div_den   = {s_eff, 1'b0};
         end
         OP_DIV_ALONG: begin
            div_start = 1'b1;
            div_num   = DIV_NW'({ext_ff, 2'b00});
            div_den   = DIV_DW'({segs_eff, 1'b0});
         end
         OP_SMOOTH: begin
            div_start = status.need_div;
            div_num   = DIV_NW'({d_lo, 16'h0000});
            div_den   = DIV_DW'(e1_ff - e0_ff);
         end
         OP_SQRT: begin
            sq_start = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            fx_ff     <= req_focus_x;
            fz_ff     <= req_focus_z;
            aoff_ff   <= in_aoff;
            neg_ff    <= req_line_offset[10];
            orient_ff <= req_orientation;
            cmag_ff   <= in_aoff * s_eff;
         end
         OP_CLASSIFY: begin
            ext_ff <= 26'(cfg.half_extent * s_eff);
            if (aoff_ff == 11'd0) begin
               color_ff  <= orient_ff ? cfg.axis_colors[23:0] : cfg.axis_colors[47:24];
               e0_ff     <= cfg.axis_fade_and_bg[15:0];
               e1_ff     <= cfg.axis_fade_and_bg[31:16];
               reject_ff <= 1'b0;
            end else if ((cfg.major_interval != 10'd0) && (div_rem == '0)) begin
               color_ff  <= cfg.tier_colors[47:24];
               e0_ff     <= cfg.minor_major_fades[47:32];
               e1_ff     <= cfg.minor_major_fades[63:48];
               reject_ff <= 1'b0;
            end else begin
               color_ff  <= cfg.tier_colors[23:0];
               e0_ff     <= cfg.minor_major_fades[15:0];
               e1_ff     <= cfg.minor_major_fades[31:16];
               reject_ff <= (cmag_ff > 27'(cfg.minor_major_fades[31:16]));
            end
         end
         OP_MUL_SNAP_X: begin
            cx_ff <= fx_ff[31] ? -$signed({1'b0, snap_mag[33:0]})
                               : $signed({1'b0, snap_mag[33:0]});
         end
         OP_MUL_SNAP_Z: begin
            cz_ff <= fz_ff[31] ? -$signed({1'b0, snap_mag[33:0]})
                               : $signed({1'b0, snap_mag[33:0]});
         end
         OP_INIT_ALONG: begin
            aq_ff   <= div_quot[26:0];
            ar_ff   <= div_rem[6:0];
            accq_ff <= '0;
            accr_ff <= {1'b0, segs_eff};
            k_ff    <= '0;
         end
         OP_SQUARE_X: begin
            sqx_ff  <= adx * adx;
            adz_ff  <= adz;
            posx_ff <= sat32(px);
            posz_ff <= sat32(pz);
         end
         OP_SQUARE_SUM: begin
            sum_ff <= sqx_ff + adz_ff * adz_ff;
         end
         OP_SMOOTH: begin
            if (e1_ff <= e0_ff) begin
               t_ff <= (sq_root < 27'(e0_ff)) ? 17'd0 : 17'h10000;
            end else if (sq_root <= 27'(e0_ff)) begin
               t_ff <= 17'd0;
            end else if (sq_root >= 27'(e1_ff)) begin
               t_ff <= 17'h10000;
            end
         end
         OP_T_LOAD: begin
            t_ff <= div_quot[16:0];
         end
         OP_F_SQUARE: begin
            tt_ff <= t_ff * t_ff;
            w_ff  <= 18'd196608 - {t_ff, 1'b0};
         end
         OP_F_CUBIC: begin
            f_ff <= fround[48:32];
         end
         OP_BLEND: begin
            red_ff   <= chan[0];
            green_ff <= chan[1];
            blue_ff  <= chan[2];
         end
         OP_NEXT: begin
            k_ff <= k_ff + 6'd1;
            if (!k_ff[0]) begin
               if (acc_r_sum >= {1'b0, segs_eff, 1'b0}) begin
                  accr_ff <= 7'(acc_r_sum - {1'b0, segs_eff, 1'b0});
                  accq_ff <= accq_ff + aq_ff + 27'd1;
               end else begin
                  accr_ff <= acc_r_sum[6:0];
                  accq_ff <= accq_ff + aq_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         ca       = color_ff[16 - 8 * ch +: 8];
         cb       = cfg.axis_fade_and_bg[48 - 8 * ch +: 8];
         cdiff    = $signed({1'b0, cb}) - $signed({1'b0, ca});
         cprod    = cdiff * $signed({1'b0, f_ff});
         ctot     = $signed({4'b0000, ca, 16'h8000}) + 28'(cprod);
         chan[ch] = ctot[23:16];
      end
   end

   glvg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   glvg_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign status.div_done     = div_done;
   assign status.sqrt_done    = sq_done;
   assign status.out_of_range = (aoff_ff > {1'b0, cfg.half_extent});
   assign status.reject       = reject_ff;
   assign status.need_div     = (e1_ff > e0_ff) && (sq_root > 27'(e0_ff))
                                && (sq_root < 27'(e1_ff));
   assign status.last         = ({1'b0, k_ff} == (7'({segs_eff, 1'b0}) - 7'd1));

   assign rsp_vertex_x    = posx_ff;
   assign rsp_vertex_z    = posz_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_last_vertex = status.last;

endmodule

@@ hw/rtl/glvg_ctrl.sv @@
module glvg_ctrl import glvg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RANGE,
      ST_MAJ_WAIT,
      ST_REJECT,
      ST_SNX_WAIT,
      ST_SNZ_START,
      ST_SNZ_WAIT,
      ST_ALG_START,
      ST_ALG_WAIT,
      ST_SQ_X,
      ST_SQ_SUM,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_SMOOTH,
      ST_T_WAIT,
      ST_F_SQUARE,
      ST_F_CUBIC,
      ST_BLEND,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (status.out_of_range) begin
               state_in = ST_IDLE;
            end else begin
               cmd.op   = OP_DIV_MAJOR;
               state_in = ST_MAJ_WAIT;
            end
         end
         ST_MAJ_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_CLASSIFY;
               state_in = ST_REJECT;
            end
         end
         ST_REJECT: begin
            if (status.reject) begin
               state_in = ST_IDLE;
            end else begin
               cmd.op   = OP_DIV_SNAP_X;
               state_in = ST_SNX_WAIT;
            end
         end
         ST_SNX_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_MUL_SNAP_X;
               state_in = ST_SNZ_START;
            end
         end
         ST_SNZ_START: begin
            cmd.op   = OP_DIV_SNAP_Z;
            state_in = ST_SNZ_WAIT;
         end
         ST_SNZ_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_MUL_SNAP_Z;
               state_in = ST_ALG_START;
            end
         end
         ST_ALG_START: begin
            cmd.op   = OP_DIV_ALONG;
            state_in = ST_ALG_WAIT;
         end
         ST_ALG_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_INIT_ALONG;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            cmd.op   = OP_SQUARE_X;
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            cmd.op   = OP_SQUARE_SUM;
            state_in = ST_SQRT_START;
         end
         ST_SQRT_START: begin
            cmd.op   = OP_SQRT;
            state_in = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               state_in = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            cmd.op   = OP_SMOOTH;
            state_in = status.need_div ? ST_T_WAIT : ST_F_SQUARE;
         end
         ST_T_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_T_LOAD;
               state_in = ST_F_SQUARE;
            end
         end
         ST_F_SQUARE: begin
            cmd.op   = OP_F_SQUARE;
            state_in = ST_F_CUBIC;
         end
         ST_F_CUBIC: begin
            cmd.op   = OP_F_CUBIC;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            cmd.op   = OP_BLEND;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.op   = OP_NEXT;
            state_in = status.last ? ST_IDLE : ST_SQ_X;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

endmodule

@@ hw/rtl/grid_line_vertex_generator_unit.sv @@
// Generates the vertices of one grid line per item: an item is taken when start is high
// and busy is low, and yields zero or 2*segments vertices, each shown for exactly one
// cycle with rsp_valid high; the receiver cannot stall, so it must take every vertex as
// it appears. A line is set up mostly by four passes of the shared serial divider,
// and each vertex then waits on the square root, with another pass of the divider
// when the fade ramp needs it. A line outside the half extent ends at the range check,
// and a minor line beyond its fade end ends at its classification.
// Configuration must be written only while busy is low; the block does not enforce it.
module grid_line_vertex_generator_unit import glvg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_focus_x,
   input  logic signed [31:0] req_focus_z,
   input  logic signed [10:0] req_line_offset,
   input  logic               req_orientation,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_z,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_last_vertex,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{cell_spacing: 16'd16, half_extent: 10'd32, segment_count: 6'd16,
                     major_interval: 10'd10, minor_major_fades: 64'd0,
                     axis_fade_and_bg: 56'd0, axis_colors: 48'd0, tier_colors: 48'd0};
      end else if (csr_valid && csr_ready && !csr_index[3]) begin
         case (reg_index_type'(csr_index[2:0]))
            REG_CELL_SPACING:      cfg_ff.cell_spacing      <= csr_wdata[15:0];
            REG_HALF_EXTENT:       cfg_ff.half_extent       <= csr_wdata[9:0];
            REG_SEGMENT_COUNT:     cfg_ff.segment_count     <= csr_wdata[5:0];
            REG_MAJOR_INTERVAL:    cfg_ff.major_interval    <= csr_wdata[9:0];
            REG_MINOR_MAJOR_FADES: cfg_ff.minor_major_fades <= csr_wdata;
            REG_AXIS_FADE_AND_BG:  cfg_ff.axis_fade_and_bg  <= csr_wdata[55:0];
            REG_AXIS_COLORS:       cfg_ff.axis_colors       <= csr_wdata[47:0];
            REG_TIER_COLORS:       cfg_ff.tier_colors       <= csr_wdata[47:0];
            default: begin
            end
         endcase
      end
   end

   glvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   glvg_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .req_focus_x     (req_focus_x),
      .req_focus_z     (req_focus_z),
      .req_line_offset (req_line_offset),
      .req_orientation (req_orientation),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_z    (rsp_vertex_z),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_last_vertex (rsp_last_vertex)
   );

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("A vertex was shown while the block was idle.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("An accepted item did not make the block busy.");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_vertex |=> !busy)
      else $error("The block stayed busy after the last vertex of a line.");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb import glvg_pkg::*; ();

   typedef struct {
      logic signed [31:0] vx;
      logic signed [31:0] vz;
      logic [7:0]         r;
      logic [7:0]         g;
      logic [7:0]         b;
      logic               last;
   } vertex_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_focus_x = '0;
   logic signed [31:0] req_focus_z = '0;
   logic signed [10:0] req_line_offset = '0;
   logic               req_orientation = 1'b0;
   logic               rsp_valid;
   logic signed [31:0] rsp_vertex_x;
   logic signed [31:0] rsp_vertex_z;
   logic [7:0]         rsp_red;
   logic [7:0]         rsp_green;
   logic [7:0]         rsp_blue;
   logic               rsp_last_vertex;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   cfg_type    grid_cfg;
   vertex_type vertex_queue[$];
   int         mismatch_count = 0;
   bit         quiet = 1'b0;

   grid_line_vertex_generator_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic longint snap_to_cell(longint f, longint unsigned s);
      longint unsigned af;
      longint unsigned mag;
      af = (f < 0) ? longint'(-f) : longint'(f);
      mag = ((2 * af + s) / (2 * s)) * s;
      return (f < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned fade_factor(longint unsigned e0, longint unsigned e1,
                                                   longint unsigned d);
      longint unsigned t;
      if (e1 <= e0) return (d < e0) ? 0 : 65536;
      if (d <= e0) t = 0;
      else if (d >= e1) t = 65536;
      else t = ((d - e0) << 16) / (e1 - e0);
      return (t * t * (196608 - 2 * t) + (64'd1 << 31)) >> 32;
   endfunction

   function automatic logic [7:0] mix_channel(longint unsigned a, longint unsigned b,
                                              longint unsigned f);
      longint unsigned m;
      m = (a * (65536 - f) + b * f + 32768) >> 16;
      return m[7:0];
   endfunction

   function automatic logic signed [31:0] clamp_pos(longint p);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   function automatic void predict_line(logic signed [31:0] fx, logic signed [31:0] fz,
                                        logic signed [10:0] off, logic ori);
      longint unsigned sp, he, segs, aoff, major, color, e0, e1, fade, frac, q, d, f;
      longint          cx, cz, c, ext, along, dx, dz;
      vertex_type      v;
      sp = (grid_cfg.cell_spacing == 0) ? 1 : grid_cfg.cell_spacing;
      he = grid_cfg.half_extent;
      segs = grid_cfg.segment_count;
      major = grid_cfg.major_interval;
      if (segs == 0) segs = 1;
      if (segs > MAX_SEGMENTS) segs = MAX_SEGMENTS;
      aoff = (off < 0) ? longint'(-longint'(off)) : longint'(off);
      if (aoff > he) return;
      if (aoff == 0) begin
         color = ori ? grid_cfg.axis_colors[23:0] : grid_cfg.axis_colors[47:24];
         e0 = grid_cfg.axis_fade_and_bg[15:0];
         e1 = grid_cfg.axis_fade_and_bg[31:16];
      end else if (major != 0 && (aoff % major) == 0) begin
         color = grid_cfg.tier_colors[47:24];
         e0 = grid_cfg.minor_major_fades[47:32];
         e1 = grid_cfg.minor_major_fades[63:48];
      end else begin
         color = grid_cfg.tier_colors[23:0];
         e0 = grid_cfg.minor_major_fades[15:0];
         e1 = grid_cfg.minor_major_fades[31:16];
         if (aoff * sp > e1) return;
      end
      fade = grid_cfg.axis_fade_and_bg[55:32];
      cx = snap_to_cell(longint'(fx), sp);
      cz = snap_to_cell(longint'(fz), sp);
      c = longint'(aoff * sp);
      if (off < 0) c = -c;
      ext = longint'(he * sp);
      for (longint unsigned k = 0; k < 2 * segs; k++) begin
         frac = (k >> 1) + (k & 1);
         q = (4 * longint'(ext) * frac + segs) / (2 * segs);
         along = longint'(q) - ext;
         dx = ori ? along : c;
         dz = ori ? c : along;
         d = int_sqrt(longint'(dx * dx) + longint'(dz * dz));
         f = fade_factor(e0, e1, d);
         v.vx = clamp_pos(cx + dx);
         v.vz = clamp_pos(cz + dz);
         v.r = mix_channel((color >> 16) & 255, (fade >> 16) & 255, f);
         v.g = mix_channel((color >> 8) & 255, (fade >> 8) & 255, f);
         v.b = mix_channel(color & 255, fade & 255, f);
         v.last = (k == 2 * segs - 1);
         vertex_queue.insert(vertex_queue.size(), v);
      end
   endfunction

   always @(posedge clock) begin
      vertex_type exp_v;
      if (!reset && rsp_valid) begin
         if (vertex_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected vertex x=%0d z=%0d", rsp_vertex_x, rsp_vertex_z);
         end else begin
            exp_v = vertex_queue.pop_front();
            if (rsp_vertex_x !== exp_v.vx || rsp_vertex_z !== exp_v.vz ||
                rsp_red !== exp_v.r || rsp_green !== exp_v.g || rsp_blue !== exp_v.b ||
                rsp_last_vertex !== exp_v.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("vertex mismatch: exp %0d %0d %h%h%h %b, got %0d %0d %h%h%h %b",
                           exp_v.vx, exp_v.vz, exp_v.r, exp_v.g, exp_v.b, exp_v.last,
                           rsp_vertex_x, rsp_vertex_z, rsp_red, rsp_green, rsp_blue,
                           rsp_last_vertex);
            end
         end
      end
   end

   task automatic send_line(logic signed [31:0] fx, logic signed [31:0] fz,
                            logic signed [10:0] off, logic ori);
      @(negedge clock);
      req_focus_x = fx;
      req_focus_z = fz;
      req_line_offset = off;
      req_orientation = ori;
      start = 1'b1;
      do @(posedge clock); while (busy);
      predict_line(fx, fz, off, ori);
      if (!quiet && $urandom_range(0, 99) < 37) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (vertex_queue.size() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [63:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = {1'b0, idx};
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_CELL_SPACING:      grid_cfg.cell_spacing = val[15:0];
         REG_HALF_EXTENT:       grid_cfg.half_extent = val[9:0];
         REG_SEGMENT_COUNT:     grid_cfg.segment_count = val[5:0];
         REG_MAJOR_INTERVAL:    grid_cfg.major_interval = val[9:0];
         REG_MINOR_MAJOR_FADES: grid_cfg.minor_major_fades = val;
         REG_AXIS_FADE_AND_BG:  grid_cfg.axis_fade_and_bg = val[55:0];
         REG_AXIS_COLORS:       grid_cfg.axis_colors = val[47:0];
         REG_TIER_COLORS:       grid_cfg.tier_colors = val[47:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(logic [15:0] sp, logic [9:0] he, logic [5:0] segs,
                            logic [9:0] major, logic [63:0] fades, logic [55:0] afb,
                            logic [47:0] axc, logic [47:0] tc);
      write_reg(REG_CELL_SPACING, sp);
      write_reg(REG_HALF_EXTENT, he);
      write_reg(REG_SEGMENT_COUNT, segs);
      write_reg(REG_MAJOR_INTERVAL, major);
      write_reg(REG_MINOR_MAJOR_FADES, fades);
      write_reg(REG_AXIS_FADE_AND_BG, afb);
      write_reg(REG_AXIS_COLORS, axc);
      write_reg(REG_TIER_COLORS, tc);
   endtask

   task automatic test_reset_values();
      send_line(32'sd0, 32'sd0, 11'sd0, 1'b0);
      send_line(32'sd25, -32'sd24, 11'sd0, 1'b1);
      send_line(-32'sd8, 32'sd8, 11'sd10, 1'b0);
      send_line(32'sd100, 32'sd7, -11'sd10, 1'b1);
      send_line(32'sd0, 32'sd0, 11'sd3, 1'b0);
      send_line(32'sd0, 32'sd0, 11'sd33, 1'b0);
      send_line(32'sd0, 32'sd0, -11'sd1023, 1'b1);
      wait_idle();
   endtask

   task automatic test_extremes();
      write_all(16'hFFFF, 10'd1023, 6'd0, 10'd0, 64'hFFFF_FFFF_0000_FFFF,
                56'hFFFFFF_0100_0000, 48'hFFFFFF_000000, 48'h000000_FFFFFF);
      send_line(32'sh7FFF_FFFF, 32'sh8000_0000, 11'sd1023, 1'b0);
      send_line(32'sh8000_0000, 32'sh7FFF_FFFF, -11'sd1023, 1'b1);
      send_line(32'sd0, 32'sd0, 11'sd0, 1'b0);
      send_line(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 11'sd0, 1'b1);
      wait_idle();
      write_all(16'd0, 10'd0, 6'd63, 10'd1023, 64'h0040_0010_0030_0008,
                56'h123456_0020_0004, 48'hA5A5A5_5A5A5A, 48'h0F0F0F_F0F0F0);
      send_line(32'sd5, -32'sd5, 11'sd0, 1'b0);
      send_line(32'sd5, -32'sd5, 11'sd1, 1'b0);
      wait_idle();
      write_all(16'd3, 10'd8, 6'd2, 10'd1, 64'h0004_0040_0040_0004,
                56'h000000_0000_0008, 48'h00FF00_FF0000, 48'h0000FF_FFFFFF);
      send_line(32'sd4, 32'sd7, 11'sd1, 1'b0);
      send_line(-32'sd4, -32'sd7, -11'sd2, 1'b1);
      send_line(-32'sd3, 32'sd3, 11'sd8, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_lines(int count, bit pause_midway);
      logic signed [31:0] fx, fz;
      logic signed [10:0] off;
      int                 he;
      write_reg(REG_CELL_SPACING,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 64));
      he = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 40);
      write_reg(REG_HALF_EXTENT, he);
      write_reg(REG_SEGMENT_COUNT, ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 3));
      write_reg(REG_MAJOR_INTERVAL, $urandom_range(0, 8));
      write_reg(REG_MINOR_MAJOR_FADES, {$urandom, $urandom_range(0, 3) == 0 ? 16'($urandom) :
                                        16'hFFFF, 16'($urandom)});
      write_reg(REG_AXIS_FADE_AND_BG, {24'($urandom), 16'($urandom), 16'($urandom)});
      write_reg(REG_AXIS_COLORS, {16'($urandom), $urandom});
      write_reg(REG_TIER_COLORS, {16'($urandom), $urandom});
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 1)) begin
            fx = $urandom;
            fz = $urandom;
         end else begin
            fx = $urandom_range(0, 8000) - 4000;
            fz = $urandom_range(0, 8000) - 4000;
         end
         if ($urandom_range(0, 99) < 15) off = 11'($urandom_range(0, 2046) - 1023);
         else if (he > 12 && $urandom_range(0, 1)) off = 11'($urandom_range(0, 12));
         else off = 11'($urandom_range(0, he));
         if ($urandom_range(0, 1)) off = -off;
         send_line(fx, fz, off, 1'($urandom_range(0, 1)));
         if (pause_midway && i == count / 2) wait_idle();
      end
      wait_idle();
   endtask

   initial begin
      grid_cfg = '{cell_spacing: 16, half_extent: 32, segment_count: 16,
                   major_interval: 10, default: '0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_extremes();
      test_random_lines(63, 1'b1);
      test_random_lines(63, 1'b0);
      quiet = 1'b1;
      test_random_lines(63, 1'b0);
      quiet = 1'b0;
      test_random_lines(63, 1'b1);
      test_random_lines(63, 1'b0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && vertex_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
